// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the I2C master RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define I2CM_ASSERT_IMPL(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define I2CM_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and constants of the byte-level I2C master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;
  // longest delay is 4 units of 65535 ticks
  localparam int DELAY_W     = 18;

  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_POLL_LIMIT = 8'd1;

  localparam logic [15:0] TICKS_RESET = 16'd1;
  localparam logic [7:0]  POLL_RESET  = 8'd200;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_WRITE    = 3'd3,
    OP_READ     = 3'd4,
    OP_ACK      = 3'd5,
    OP_NACK     = 3'd6,
    OP_WAIT_ACK = 3'd7
  } opcode_t;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST2, PH_ST3, PH_SP2, PH_SP3, PH_FIN, PH_AK2, PH_AK3, PH_AK4,
    PH_WR1, PH_WR2, PH_WR3, PH_RD1, PH_RD2, PH_RD3, PH_WA2, PH_WA3, PH_WAP,
    PH_WAF, PH_WA5, PH_WA6, PH_WA7
  } phase_t;

  typedef enum logic [1:0] {
    WAIT_NONE, WAIT_1, WAIT_2, WAIT_4
  } wait_t;

  // one classified tick as it sits in the queue
  typedef struct packed {
    logic          is_cmd;
    opcode_t       op;
    logic [7:0]    data_byte;
    logic          sda_in;
  } tick_t;

  typedef struct packed {
    logic          ack_missing;
    logic [7:0]    read_data;
    logic          done;
    logic          busy;
    logic          sda_oe;
    logic          sda;
    logic          scl;
  } result_t;

endpackage

// ===== rtl/core/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// Input side: unpacks the stream word and classifies the tick.
// ----------------------------------------------------------------------------
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [2:0]            in_tuser,
  output logic                  q_push,
  output tick_t                 q_item,
  input  logic                  q_full
);

  opcode_t op;

  assign op        = opcode_t'(in_tuser);
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_item.is_cmd    = (op != OP_TICK);
    q_item.op        = op;
    q_item.data_byte = in_tdata[7:0];
    q_item.sda_in    = in_tdata[8];
  end

endmodule

// ===== rtl/core/i2cm_queue.sv =====
// ----------------------------------------------------------------------------
// i2cm_queue
// Small FIFO of classified ticks between front and sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cm_queue
  import i2cm_pkg::*;
#(
  parameter int DEPTH = 4
)
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  tick_t push_item,
  output logic  full,
  input  logic  pop,
  output tick_t pop_item,
  output logic  not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  tick_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_FULL);
  assign not_empty = (count_r != '0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `I2CM_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, pop, count_r != '0, "pop from empty queue")
  `I2CM_ASSERT_IMPL(a_no_push_full, clk, rst_n, push, count_r != CNT_FULL, "push into full queue")
  `I2CM_ASSERT_IMPL(a_ptr_gap, clk, rst_n, count_r == '0, wr_ptr_r == rd_ptr_r, "pointers apart while empty")

endmodule

// ===== rtl/core/i2cm_back.sv =====
// ----------------------------------------------------------------------------
// i2cm_back
// Bit sequencer: runs one tick per queue word and registers the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cm_back
  import i2cm_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   q_valid,
  input  tick_t                  q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output result_t                out_res
);

  logic [15:0]        ticks_r;
  logic [7:0]         poll_limit_r;

  phase_t             phase_r, phase_nxt;
  logic [3:0]         bit_count_r, bit_count_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [DELAY_W-1:0] delay_r, delay_nxt;
  logic [7:0]         poll_r, poll_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               oe_r, oe_nxt;
  logic [7:0]         read_r, read_nxt;
  logic               ack_r, ack_nxt;
  logic               done_nxt;
  logic               out_valid_r;
  result_t            res_r;

  logic               busy;
  logic               fire;
  logic               start;
  logic [DELAY_W-1:0] delay_dec;
  logic [DELAY_W-1:0] unit_len;
  logic [3:0]         bit_inc;
  logic [7:0]         poll_dec;
  wait_t              wait_sel;

  assign q_pop     = q_valid && (!out_valid_r || out_ready);
  assign busy      = (phase_r != PH_IDLE);
  assign delay_dec = delay_r - 1'b1;
  assign fire      = busy && (delay_dec == '0);
  assign start     = !busy && q_item.is_cmd;
  assign bit_inc   = bit_count_r + 4'd1;
  assign poll_dec  = poll_r - 8'd1;
  assign unit_len  = {2'b00, (ticks_r == '0) ? 16'd1 : ticks_r};

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r      <= TICKS_RESET;
      poll_limit_r <= POLL_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TICKS_PER_UNIT) begin
        ticks_r <= cfg_data;
      end else if (cfg_index == REG_ACK_POLL_LIMIT) begin
        poll_limit_r <= cfg_data[7:0];
      end
    end
  end

  // next phase and delay selection
  always_comb begin
    phase_nxt = phase_r;
    wait_sel  = WAIT_NONE;
    if (q_pop && fire) begin
      case (phase_r)
        PH_ST2: begin phase_nxt = PH_ST3; wait_sel = WAIT_4; end
        PH_SP2: begin phase_nxt = PH_SP3; wait_sel = WAIT_4; end
        PH_SP3: begin phase_nxt = PH_FIN; wait_sel = WAIT_4; end
        PH_AK2: begin phase_nxt = PH_AK3; wait_sel = WAIT_2; end
        PH_AK3: begin phase_nxt = PH_AK4; wait_sel = WAIT_2; end
        PH_AK4: begin phase_nxt = PH_FIN; wait_sel = WAIT_1; end
        PH_WR1: begin phase_nxt = PH_WR2; wait_sel = WAIT_2; end
        PH_WR2: begin phase_nxt = PH_WR3; wait_sel = WAIT_2; end
        PH_WR3: begin
          phase_nxt = bit_inc[3] ? PH_FIN : PH_WR1;
          wait_sel  = WAIT_2;
        end
        PH_RD1: begin phase_nxt = PH_RD2; wait_sel = WAIT_2; end
        PH_RD2: begin
          phase_nxt = bit_inc[3] ? PH_RD3 : PH_RD1;
          wait_sel  = WAIT_1;
        end
        PH_WA2: begin phase_nxt = PH_WA3; wait_sel = WAIT_1; end
        PH_WA3: begin phase_nxt = PH_WAP; wait_sel = WAIT_1; end
        PH_WAP: begin
          if (!q_item.sda_in) begin
            phase_nxt = PH_WA5;
            wait_sel  = WAIT_1;
          end else if (poll_dec == '0) begin
            phase_nxt = PH_WAF;
            wait_sel  = WAIT_1;
          end else begin
            phase_nxt = PH_WAP;
            wait_sel  = WAIT_2;
          end
        end
        PH_WA5: begin phase_nxt = PH_WA6; wait_sel = WAIT_1; end
        PH_WA6: begin phase_nxt = PH_WA7; wait_sel = WAIT_1; end
        default: phase_nxt = PH_IDLE;   // ST3, FIN, RD3, WAF, WA7 finish
      endcase
    end else if (q_pop && start) begin
      case (q_item.op)
        OP_START:    begin phase_nxt = PH_ST2; wait_sel = WAIT_4; end
        OP_STOP:     begin phase_nxt = PH_SP2; wait_sel = WAIT_4; end
        OP_WRITE:    begin phase_nxt = PH_WR2; wait_sel = WAIT_2; end
        OP_READ:     begin phase_nxt = PH_RD1; wait_sel = WAIT_1; end
        OP_ACK,
        OP_NACK:     begin phase_nxt = PH_AK2; wait_sel = WAIT_2; end
        OP_WAIT_ACK: begin phase_nxt = PH_WA2; wait_sel = WAIT_1; end
        default:     phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_comb begin
    case (wait_sel)
      WAIT_1:  delay_nxt = unit_len;
      WAIT_2:  delay_nxt = unit_len << 1;
      WAIT_4:  delay_nxt = unit_len << 2;
      default: delay_nxt = (q_pop && busy) ? delay_dec : delay_r;
    endcase
  end

  // line and data register actions
  always_comb begin
    bit_count_nxt = bit_count_r;
    shift_nxt     = shift_r;
    poll_nxt      = poll_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    oe_nxt        = oe_r;
    read_nxt      = read_r;
    ack_nxt       = ack_r;
    done_nxt      = 1'b0;
    if (q_pop && fire) begin
      case (phase_r)
        PH_ST2: sda_nxt = 1'b0;
        PH_ST3: begin scl_nxt = 1'b0; done_nxt = 1'b1; end
        PH_SP2: scl_nxt = 1'b1;
        PH_SP3: sda_nxt = 1'b1;
        PH_FIN: done_nxt = 1'b1;
        PH_AK2: sda_nxt = shift_r[0];
        PH_AK3: scl_nxt = 1'b1;
        PH_AK4: scl_nxt = 1'b0;
        PH_WR1: begin
          sda_nxt   = shift_r[7];
          shift_nxt = {shift_r[6:0], 1'b0};
        end
        PH_WR2: scl_nxt = 1'b1;
        PH_WR3: begin scl_nxt = 1'b0; bit_count_nxt = bit_inc; end
        PH_RD1: scl_nxt = 1'b0;
        PH_RD2: begin
          scl_nxt       = 1'b1;
          shift_nxt     = {shift_r[6:0], q_item.sda_in};
          bit_count_nxt = bit_inc;
        end
        PH_RD3: begin scl_nxt = 1'b0; read_nxt = shift_r; done_nxt = 1'b1; end
        PH_WA2: scl_nxt = 1'b0;
        PH_WA3: oe_nxt = 1'b0;
        PH_WAP: begin
          if (q_item.sda_in) begin
            poll_nxt = poll_dec;
          end
        end
        PH_WAF: begin scl_nxt = 1'b0; ack_nxt = 1'b1; done_nxt = 1'b1; end
        PH_WA5: scl_nxt = 1'b1;
        PH_WA6: scl_nxt = 1'b0;
        PH_WA7: begin ack_nxt = 1'b0; done_nxt = 1'b1; end
        default: ;
      endcase
    end else if (q_pop && start) begin
      case (q_item.op)
        OP_START: begin oe_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1; end
        OP_STOP:  begin oe_nxt = 1'b1; scl_nxt = 1'b0; sda_nxt = 1'b0; end
        OP_WRITE: begin
          // first data bit goes out on the accept tick
          oe_nxt        = 1'b1;
          scl_nxt       = 1'b0;
          sda_nxt       = q_item.data_byte[7];
          shift_nxt     = {q_item.data_byte[6:0], 1'b0};
          bit_count_nxt = 4'd0;
        end
        OP_READ: begin
          oe_nxt        = 1'b0;
          shift_nxt     = 8'd0;
          bit_count_nxt = 4'd0;
        end
        OP_ACK, OP_NACK: begin
          oe_nxt    = 1'b1;
          scl_nxt   = 1'b0;
          shift_nxt = {7'd0, q_item.op == OP_NACK};
        end
        OP_WAIT_ACK: begin
          poll_nxt = poll_limit_r;
          oe_nxt   = 1'b1;
          sda_nxt  = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_count_r <= '0;
      shift_r     <= '0;
      delay_r     <= '0;
      poll_r      <= '0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      oe_r        <= 1'b1;
      read_r      <= '0;
      ack_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bit_count_r <= bit_count_nxt;
      shift_r     <= shift_nxt;
      delay_r     <= delay_nxt;
      poll_r      <= poll_nxt;
      scl_r       <= scl_nxt;
      sda_r       <= sda_nxt;
      oe_r        <= oe_nxt;
      read_r      <= read_nxt;
      ack_r       <= ack_nxt;
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r.scl         <= scl_nxt;
      res_r.sda         <= sda_nxt;
      res_r.sda_oe      <= oe_nxt;
      res_r.busy        <= (phase_nxt != PH_IDLE);
      res_r.done        <= done_nxt;
      res_r.read_data   <= read_nxt;
      res_r.ack_missing <= ack_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  `I2CM_ASSERT_IMPL(a_delay_loaded, clk, rst_n, phase_r != PH_IDLE, delay_r != '0, "running with empty delay")
  `I2CM_ASSERT_IMPL(a_done_idle, clk, rst_n, out_valid_r && res_r.done, !res_r.busy, "done word still busy")
  `I2CM_ASSERT_NEXT(a_tick_stays_idle, clk, rst_n, q_pop && !busy && !q_item.is_cmd, phase_r == PH_IDLE, "plain tick left idle")

endmodule

// ===== rtl/core/i2c_bit_level_master_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_bit_level_master_unit
// Byte-level I2C master: tick stream in, line levels and status out.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake            | payload
//  ---------+-----+----------------------+--------------------------------------
//  in_      | in  | in_tvalid/in_tready  | tuser opcode, tdata byte and sda_in
//  out_     | out | out_tvalid/out_tready| tdata line levels and status
//  cfg_     | in  | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
//  One result word per input word, one word per cycle sustained; the front
//  accepts while the queue has room, the sequencer advances when the output
//  register is empty or being taken. Words pass the queue and then the output
//  register. Synchronous active-low reset; config is always ready.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_unit
  import i2cm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] data_byte, [8] sda_in
  input  logic [2:0]             in_tuser,   // [2:0] opcode
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive_enable, [3] busy_res,
  // [4] done_res, [12:5] read_data, [13] ack_missing
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_valid;
  tick_t   q_in;
  tick_t   q_out;
  result_t res;

  assign cfg_ready = 1'b1;

  i2cm_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_push    (q_push),
    .q_item    (q_in),
    .q_full    (q_full)
  );

  i2cm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_out),
    .not_empty (q_valid)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {2'b00, res.ack_missing, res.read_data, res.done, res.busy,
                      res.sda_oe, res.sda, res.scl};

endmodule
